// ===== rtl/core/obse_pkg.sv =====
// ----------------------------------------------------------------------------
// obse_pkg
// Shared codes for the output blink sequence engine: item modes, effect
// codes and the after-end selector values.
// ----------------------------------------------------------------------------
package obse_pkg;

    // item modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_ON    = 3'd1;
    localparam logic [2:0] MODE_OFF   = 3'd2;
    localparam logic [2:0] MODE_BLINK = 3'd3;
    localparam logic [2:0] MODE_SEQ   = 3'd4;
    localparam logic [2:0] MODE_WRITE = 3'd5;

    // effect codes, also shown on the effect state output
    localparam logic [1:0] EFF_OFF   = 2'd0;
    localparam logic [1:0] EFF_ON    = 2'd1;
    localparam logic [1:0] EFF_BLINK = 2'd2;
    localparam logic [1:0] EFF_SEQ   = 2'd3;

    // after-end selector; any other value repeats
    localparam logic [1:0] END_OFF = 2'd0;
    localparam logic [1:0] END_ON  = 2'd1;

    typedef logic [1:0] t_effect;

endpackage

// ===== rtl/core/obse_ram.sv =====
// ----------------------------------------------------------------------------
// obse_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module obse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/output_blink_sequence_engine.sv =====
// ----------------------------------------------------------------------------
// output_blink_sequence_engine
// Drives one output pin through steady, blink and timed sequence effects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per item: a tick
//   with elapsed time, an on/off command, a blink start, a sequence start or
//   a sequence table write. Output channel (o_out_valid / i_out_ready)
//   returns one beat per input beat: the pin level and effect code after
//   that item, in input order.
//   The result is registered at accept. Throughput is one item per cycle
//   while o_in_ready is high: all state updates for an item are done in
//   the accept cycle, and the sequence table RAM is prefetched at the step
//   the next tick will use, with a bypass for a write to that same entry.
//   The blink length multiply happens in the accept cycle of a blink start.
//   A two-entry output stage (result register plus skid register) lets one
//   more beat in while a result waits; o_in_ready drops only when both are
//   full, and rises again after the receiver takes a beat.
//   Reset (i_rst_n low, synchronous) sets the effect to off with the pin low
//   and empties the output stage. Sequence table contents are not reset and
//   must be written before a sequence uses them.
// ----------------------------------------------------------------------------
module output_blink_sequence_engine #(
    parameter int SEQ_DEPTH  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_mode,
    input  logic [TIME_WIDTH-1:0] i_step_time,
    input  logic [TIME_WIDTH-1:0] i_half_period,
    input  logic [TIME_WIDTH-1:0] i_duration,
    input  logic                  i_duration_is_count,
    input  logic [1:0]            i_after_end,
    input  logic [4:0]            i_seq_length,
    input  logic [3:0]            i_entry_index,
    input  logic [TIME_WIDTH-1:0] i_entry_value,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_pin_level,
    output logic [1:0]            o_effect_state
);

    localparam int TW = TIME_WIDTH;
    localparam int EW = TIME_WIDTH + 1;
    localparam int RW = 2 * TIME_WIDTH;
    localparam int AW = $clog2(SEQ_DEPTH);
    localparam int IW = $clog2(SEQ_DEPTH + 1);
    localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

    // effect state
    obse_pkg::t_effect r_effect, n_effect;
    obse_pkg::t_effect r_end_target, n_end_target;
    logic [EW-1:0] r_elapsed, n_elapsed;
    logic [RW-1:0] r_remaining, n_remaining;
    logic [IW-1:0] r_step_index, n_step_index;
    logic          r_pin, n_pin;
    logic [TW-1:0] r_blink_half, n_blink_half;
    logic [IW-1:0] r_seq_count, n_seq_count;
    logic          r_entry0_nz, n_entry0_nz;

    // output stage
    logic          r_out_valid, r_skid_valid;
    logic          r_out_pin, r_skid_pin;
    logic [1:0]    r_out_effect, r_skid_effect;

    // table access
    logic          r_fwd_hit;
    logic [TW-1:0] r_fwd_data;
    logic [TW-1:0] ram_rdata;
    logic [TW-1:0] step_len;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] tbl_raddr;
    logic [AW-1:0] cur_idx;

    logic          in_fire;
    logic          out_fire;
    logic [EW:0]   elapsed_sum;
    logic [EW-1:0] elapsed_add;
    logic [IW-1:0] seq_next;
    logic [31:0]   len_clamp;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;

    // step time added to elapsed, saturating
    assign elapsed_sum = {1'b0, r_elapsed} + (EW + 1)'(i_step_time);
    assign elapsed_add = elapsed_sum[EW] ? ELAPSED_MAX : elapsed_sum[EW-1:0];

    // current sequence step, held at the last entry
    assign cur_idx  = (32'(r_step_index) >= 32'(SEQ_DEPTH)) ? AW'(SEQ_DEPTH - 1)
                                                           : AW'(r_step_index);
    assign seq_next = IW'(cur_idx) + IW'(1);
    assign step_len = r_fwd_hit ? r_fwd_data : ram_rdata;

    // sequence length clamped into 1..SEQ_DEPTH
    always_comb begin
        len_clamp = 32'(i_seq_length);
        if (len_clamp == 32'd0) begin
            len_clamp = 32'd1;
        end
        if (len_clamp > 32'(SEQ_DEPTH)) begin
            len_clamp = 32'(SEQ_DEPTH);
        end
    end

    // table write from a write item inside the table
    assign tbl_we    = in_fire && (i_mode == obse_pkg::MODE_WRITE) &&
                       (32'(i_entry_index) < 32'(SEQ_DEPTH));
    assign tbl_waddr = AW'(32'(i_entry_index));

    // next state for the accepted item
    always_comb begin
        n_effect     = r_effect;
        n_end_target = r_end_target;
        n_elapsed    = r_elapsed;
        n_remaining  = r_remaining;
        n_step_index = r_step_index;
        n_pin        = r_pin;
        n_blink_half = r_blink_half;
        n_seq_count  = r_seq_count;
        n_entry0_nz  = r_entry0_nz;
        if (in_fire) begin
            case (i_mode)
                obse_pkg::MODE_TICK: begin
                    case (r_effect)
                        obse_pkg::EFF_BLINK: begin
                            n_elapsed = elapsed_add;
                            if ((r_end_target != obse_pkg::EFF_BLINK) &&
                                (RW'(i_step_time) >= r_remaining)) begin
                                // blink done: pin holds, effect falls through
                                n_remaining  = '0;
                                n_effect     = r_end_target;
                                n_step_index = '0;
                            end else begin
                                if (r_end_target != obse_pkg::EFF_BLINK) begin
                                    n_remaining = r_remaining - RW'(i_step_time);
                                end
                                if (elapsed_add >= EW'(r_blink_half)) begin
                                    n_step_index = r_step_index ^ IW'(1);
                                    n_elapsed    = elapsed_add - EW'(r_blink_half);
                                    n_pin        = ~r_step_index[0];
                                end
                            end
                        end
                        obse_pkg::EFF_SEQ: begin
                            n_elapsed = elapsed_add;
                            if (elapsed_add > EW'(step_len)) begin
                                n_elapsed = elapsed_add - EW'(step_len);
                                if (seq_next >= r_seq_count) begin
                                    // sequence done: wrap or fall to end effect
                                    n_effect     = r_end_target;
                                    n_step_index = '0;
                                    if (r_entry0_nz) begin
                                        n_pin = 1'b1;
                                    end
                                end else begin
                                    n_step_index = seq_next;
                                    n_pin        = ~seq_next[0];
                                end
                            end
                        end
                        default: begin
                            // steady on/off: settle the pin once
                            if (r_step_index == '0) begin
                                n_pin        = (r_effect == obse_pkg::EFF_ON);
                                n_step_index = IW'(1);
                            end
                        end
                    endcase
                end
                obse_pkg::MODE_ON, obse_pkg::MODE_OFF: begin
                    n_effect     = (i_mode == obse_pkg::MODE_ON) ? obse_pkg::EFF_ON
                                                                 : obse_pkg::EFF_OFF;
                    n_end_target = n_effect;
                    n_pin        = (i_mode == obse_pkg::MODE_ON);
                    n_step_index = '0;
                end
                obse_pkg::MODE_BLINK: begin
                    n_effect = obse_pkg::EFF_BLINK;
                    case (i_after_end)
                        obse_pkg::END_OFF: n_end_target = obse_pkg::EFF_OFF;
                        obse_pkg::END_ON:  n_end_target = obse_pkg::EFF_ON;
                        default:           n_end_target = obse_pkg::EFF_BLINK;
                    endcase
                    n_blink_half = i_half_period;
                    n_remaining  = i_duration_is_count ?
                                   RW'(i_duration) * RW'(i_half_period) :
                                   RW'(i_duration);
                    n_step_index = '0;
                    n_elapsed    = EW'(i_half_period);
                end
                obse_pkg::MODE_SEQ: begin
                    n_effect = obse_pkg::EFF_SEQ;
                    case (i_after_end)
                        obse_pkg::END_OFF: n_end_target = obse_pkg::EFF_OFF;
                        obse_pkg::END_ON:  n_end_target = obse_pkg::EFF_ON;
                        default:           n_end_target = obse_pkg::EFF_SEQ;
                    endcase
                    n_elapsed    = '0;
                    n_step_index = '0;
                    n_seq_count  = IW'(len_clamp);
                    if (r_entry0_nz) begin
                        n_pin = 1'b1;
                    end
                end
                obse_pkg::MODE_WRITE: begin
                    if (tbl_we && (tbl_waddr == '0)) begin
                        n_entry0_nz = (i_entry_value != '0);
                    end
                end
                default: begin
                    // unused modes leave everything unchanged
                end
            endcase
        end
    end

    // prefetch the entry the next tick will compare against
    assign tbl_raddr = (32'(n_step_index) >= 32'(SEQ_DEPTH)) ? AW'(SEQ_DEPTH - 1)
                                                            : AW'(n_step_index);

    obse_ram #(
        .WIDTH (TW),
        .DEPTH (SEQ_DEPTH)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_entry_value),
        .i_raddr (tbl_raddr),
        .o_rdata (ram_rdata)
    );

    // bypass a write that lands on the entry being prefetched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= tbl_we && (tbl_waddr == tbl_raddr);
        end
        r_fwd_data <= i_entry_value;
    end

    // effect state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect     <= obse_pkg::EFF_OFF;
            r_end_target <= obse_pkg::EFF_OFF;
            r_elapsed    <= '0;
            r_remaining  <= '0;
            r_step_index <= IW'(1);
            r_pin        <= 1'b0;
            r_blink_half <= '0;
            r_seq_count  <= '0;
        end else begin
            r_effect     <= n_effect;
            r_end_target <= n_end_target;
            r_elapsed    <= n_elapsed;
            r_remaining  <= n_remaining;
            r_step_index <= n_step_index;
            r_pin        <= n_pin;
            r_blink_half <= n_blink_half;
            r_seq_count  <= n_seq_count;
        end
        r_entry0_nz <= n_entry0_nz;
    end

    // result register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (in_fire) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
        // payload moves with the valid bits above
        if (out_fire) begin
            if (r_skid_valid) begin
                r_out_pin    <= r_skid_pin;
                r_out_effect <= r_skid_effect;
            end else begin
                r_out_pin    <= n_pin;
                r_out_effect <= n_effect;
            end
        end else if (in_fire) begin
            if (r_out_valid) begin
                r_skid_pin    <= n_pin;
                r_skid_effect <= n_effect;
            end else begin
                r_out_pin    <= n_pin;
                r_out_effect <= n_effect;
            end
        end
    end

    assign o_in_ready     = !r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_pin_level    = r_out_pin;
    assign o_effect_state = r_out_effect;

endmodule

// ===== rtl/core/obse_checker.sv =====
// ----------------------------------------------------------------------------
// obse_checker
// Port-level checks for the output blink sequence engine, bound to the top.
// ----------------------------------------------------------------------------
module obse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [2:0] i_mode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_pin_level,
    input logic [1:0] o_effect_state
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat present after reset");

    // input stalls only when a result is waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // an accepted beat into an empty output shows up next cycle
    a_one_cycle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> o_out_valid)
        else $error("result missing one cycle after accept");

    // an on command shows the pin high with effect on
    a_on_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid && (i_mode == obse_pkg::MODE_ON))
        |=> (o_pin_level && (o_effect_state == obse_pkg::EFF_ON)))
        else $error("on command did not drive the pin high");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_pin_level) && $stable(o_effect_state)))
        else $error("stalled result beat changed");

endmodule

bind output_blink_sequence_engine obse_checker u_obse_checker (.*);
